// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is asserted
`define PDB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds through reset
`define PDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pdb_pkg;

	// operator codes held in the mode register
	typedef enum logic [3:0] {
		MODE_CLEAR    = 4'd0,
		MODE_SRC      = 4'd1,
		MODE_DST      = 4'd2,
		MODE_OVER     = 4'd3,
		MODE_DST_OVER = 4'd4,
		MODE_SRC_IN   = 4'd5,
		MODE_DST_IN   = 4'd6,
		MODE_SRC_OUT  = 4'd7,
		MODE_DST_OUT  = 4'd8,
		MODE_SRC_ATOP = 4'd9,
		MODE_DST_ATOP = 4'd10,
		MODE_XOR      = 4'd11
	} blend_mode_t;

	localparam blend_mode_t MODE_RESET = MODE_OVER;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned CHANS   = 3;
	localparam int unsigned WEIGHT_W = 2 * CHAN_W;
	localparam int unsigned NUM_W   = 3 * CHAN_W;

	localparam logic [CHAN_W-1:0]   FULL_SCALE  = 8'd255;
	localparam logic [WEIGHT_W-1:0] FULL_SQUARE = 16'd65025;

	// floor(x / 65025) for x below 2^24 as (x * PRE_RECIP) >> PRE_SHIFT
	localparam int unsigned PRE_SHIFT   = 40;
	localparam int unsigned PRE_RECIP_W = 25;
	localparam logic [PRE_RECIP_W-1:0] PRE_RECIP =
		PRE_RECIP_W'(((64'd1 << PRE_SHIFT) + 64'd65024) / 64'd65025);

	// floor(x / 255) for x below 2^16 as (x * ALPHA_RECIP) >> ALPHA_SHIFT
	localparam int unsigned ALPHA_SHIFT   = 24;
	localparam int unsigned ALPHA_RECIP_W = 17;
	localparam logic [ALPHA_RECIP_W-1:0] ALPHA_RECIP =
		ALPHA_RECIP_W'(((64'd1 << ALPHA_SHIFT) + 64'd254) / 64'd255);

	// one quotient bit per divider stage
	localparam int unsigned DIV_STEPS  = CHAN_W;
	localparam int unsigned FRONT_DEPTH = 4;
	localparam int unsigned PIPE_DEPTH = FRONT_DEPTH + DIV_STEPS;

	typedef struct packed {
		logic [CHAN_W-1:0] fs;
		logic [CHAN_W-1:0] fd;
	} factors_t;

	// word moving down the divider stages
	typedef struct packed {
		logic [CHANS-1:0][NUM_W-1:0]  rem;
		logic [CHANS-1:0][CHAN_W-1:0] quo;
		logic [WEIGHT_W-1:0]          den;
		logic [CHAN_W-1:0]            alpha;
	} div_word_t;

	// source and destination factors of each operator
	function automatic factors_t pick_factors(blend_mode_t mode, logic [CHAN_W-1:0] as_v,
			logic [CHAN_W-1:0] ad_v);
		factors_t f;
		logic [CHAN_W-1:0] nas;
		logic [CHAN_W-1:0] nad;
		nas = FULL_SCALE - as_v;
		nad = FULL_SCALE - ad_v;
		unique case (mode)
			MODE_SRC: begin
				f.fs = FULL_SCALE; f.fd = '0;
			end
			MODE_DST: begin
				f.fs = '0;         f.fd = FULL_SCALE;
			end
			MODE_OVER: begin
				f.fs = FULL_SCALE; f.fd = nas;
			end
			MODE_DST_OVER: begin
				f.fs = nad;        f.fd = FULL_SCALE;
			end
			MODE_SRC_IN: begin
				f.fs = ad_v;       f.fd = '0;
			end
			MODE_DST_IN: begin
				f.fs = '0;         f.fd = as_v;
			end
			MODE_SRC_OUT: begin
				f.fs = nad;        f.fd = '0;
			end
			MODE_DST_OUT: begin
				f.fs = '0;         f.fd = nas;
			end
			MODE_SRC_ATOP: begin
				f.fs = ad_v;       f.fd = nas;
			end
			MODE_DST_ATOP: begin
				f.fs = nad;        f.fd = as_v;
			end
			MODE_XOR: begin
				f.fs = nad;        f.fd = nas;
			end
			default: begin
				f.fs = '0;         f.fd = '0;
			end
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- sv/pdb_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdb_div_pipe (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pdb_pkg::div_word_t in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pdb_pkg::div_word_t      out_word
);

	localparam int unsigned STEPS = pdb_pkg::DIV_STEPS;

	// one restoring step on all three channels, quotient bit at position sh
	function automatic pdb_pkg::div_word_t div_step(pdb_pkg::div_word_t w, int unsigned sh);
		pdb_pkg::div_word_t r;
		logic [pdb_pkg::NUM_W-1:0] trial;
		r = w;
		trial = pdb_pkg::NUM_W'(w.den) << sh;
		for (int c = 0; c < pdb_pkg::CHANS; c++) begin
			if (w.rem[c] >= trial) begin
				r.rem[c] = w.rem[c] - trial;
				r.quo[c] = {w.quo[c][pdb_pkg::CHAN_W-2:0], 1'b1};
			end else begin
				r.quo[c] = {w.quo[c][pdb_pkg::CHAN_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic               vld_s [STEPS];
	logic               rdy_s [STEPS];
	pdb_pkg::div_word_t word_s [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic               prev_vld;
		pdb_pkg::div_word_t prev_word;
		logic               next_rdy;

		// link to the neighbouring stages
		if (j == 0) begin : g_first
			assign prev_vld  = in_valid;
			assign prev_word = in_word;
		end else begin : g_mid
			assign prev_vld  = vld_s[j-1];
			assign prev_word = word_s[j-1];
		end

		if (j == STEPS - 1) begin : g_last
			assign next_rdy = out_ready;
		end else begin : g_inner
			assign next_rdy = rdy_s[j+1];
		end

		// a stage takes a word when empty or when its word moves on
		assign rdy_s[j] = !vld_s[j] || next_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy_s[j]) begin
				vld_s[j] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (prev_vld && rdy_s[j]) begin
				word_s[j] <= div_step(prev_word, STEPS - 1 - j);
			end
		end
	end

	assign in_ready  = rdy_s[0];
	assign out_valid = vld_s[STEPS-1];
	assign out_word  = word_s[STEPS-1];

endmodule

`default_nettype wire

// ----- sv/porter_duff_pixel_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Porter-Duff compositing of one source and one destination RGBA pixel.
// Input channel: in_valid / in_ready carry both pixels as one word; output
// channel: out_valid / out_ready carry the blended, unpremultiplied pixel.
// blend_mode is to be written with cfg_write only while no pixel is in
// flight; the block does not enforce this. Reset selects source-over.
// Four front stages form the alpha weights, the premultiplied sums, the
// premultiplied colour and its rescaled dividend; eight more run a restoring
// divide, one quotient bit per stage, by the combined weight.
// Throughput: one pixel per cycle while out_ready is high. Every stage
// holds a valid bit and fills whenever it is empty or its word moves on,
// so bubbles close up. When out_ready is low the last word stays on the
// outputs unchanged; the stages behind it keep taking pixels until the
// pipe is full, and in_ready falls only when all 12 stages hold a word.
// Reset clears all valid bits and loads source-over into the mode
// register; data registers are not reset.
// A combined weight of zero gives zero colour and zero alpha.
module porter_duff_pixel_blend (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [3:0] blend_mode,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] src_red,
	input  wire logic [7:0] src_green,
	input  wire logic [7:0] src_blue,
	input  wire logic [7:0] src_alpha,
	input  wire logic [7:0] dst_red,
	input  wire logic [7:0] dst_green,
	input  wire logic [7:0] dst_blue,
	input  wire logic [7:0] dst_alpha,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_red,
	output logic [7:0]      out_green,
	output logic [7:0]      out_blue,
	output logic [7:0]      out_alpha
);

	localparam int unsigned CW = pdb_pkg::CHAN_W;
	localparam int unsigned WW = pdb_pkg::WEIGHT_W;
	localparam int unsigned NW = pdb_pkg::NUM_W;
	localparam int unsigned NC = pdb_pkg::CHANS;
	localparam int unsigned PRE_PROD_W   = NW + pdb_pkg::PRE_RECIP_W;
	localparam int unsigned ALPHA_PROD_W = WW + pdb_pkg::ALPHA_RECIP_W;

	// mode register
	pdb_pkg::blend_mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pdb_pkg::MODE_RESET;
		end else if (cfg_write) begin
			mode_q <= pdb_pkg::blend_mode_t'(blend_mode);
		end
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic div_in_ready;

	assign rdy_s4   = !v_s4 || div_in_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: factors and alpha weights
	pdb_pkg::factors_t          fac;
	logic [WW-1:0]              ws_s1, wd_s1;
	logic [NC-1:0][CW-1:0]      src_s1, dst_s1;

	assign fac = pdb_pkg::pick_factors(mode_q, src_alpha, dst_alpha);

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			ws_s1  <= WW'(src_alpha) * WW'(fac.fs);
			wd_s1  <= WW'(dst_alpha) * WW'(fac.fd);
			src_s1 <= {src_blue, src_green, src_red};
			dst_s1 <= {dst_blue, dst_green, dst_red};
		end
	end

	// stage 2: premultiplied sums and combined weight
	logic [NC-1:0][NW-1:0] num_d;
	logic [WW:0]           den_sum;
	logic [NC-1:0][NW-1:0] num_s2;
	logic [WW-1:0]         den_s2;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			num_d[c] = NW'((NW+1)'(NW'(src_s1[c]) * NW'(ws_s1))
				+ (NW+1)'(NW'(dst_s1[c]) * NW'(wd_s1)));
		end
		den_sum = (WW+1)'(ws_s1) + (WW+1)'(wd_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			num_s2 <= num_d;
			den_s2 <= den_sum[WW-1:0];
		end
	end

	// stage 3: premultiplied colour and alpha by reciprocal
	logic [NC-1:0][PRE_PROD_W-1:0] pre_prod;
	logic [ALPHA_PROD_W-1:0]       alpha_prod;
	logic [NC-1:0][CW-1:0]         p_s3;
	logic [WW-1:0]                 den_s3;
	logic [CW-1:0]                 alpha_s3;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			pre_prod[c] = PRE_PROD_W'(num_s2[c]) * PRE_PROD_W'(pdb_pkg::PRE_RECIP);
		end
		alpha_prod = ALPHA_PROD_W'(den_s2) * ALPHA_PROD_W'(pdb_pkg::ALPHA_RECIP);
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			for (int c = 0; c < NC; c++) begin
				p_s3[c] <= pre_prod[c][pdb_pkg::PRE_SHIFT +: CW];
			end
			den_s3   <= den_s2;
			alpha_s3 <= alpha_prod[pdb_pkg::ALPHA_SHIFT +: CW];
		end
	end

	// stage 4: dividend for unpremultiply, zero weight divides 0 by 1
	logic [NC-1:0][NW-1:0] dvd_s4;
	logic [WW-1:0]         den_s4;
	logic [CW-1:0]         alpha_s4;

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			for (int c = 0; c < NC; c++) begin
				dvd_s4[c] <= NW'(p_s3[c]) * NW'(pdb_pkg::FULL_SQUARE);
			end
			den_s4   <= (den_s3 == '0) ? WW'(1) : den_s3;
			alpha_s4 <= alpha_s3;
		end
	end

	// divide pipe
	pdb_pkg::div_word_t div_in, div_out;

	always_comb begin
		div_in.rem   = dvd_s4;
		div_in.quo   = '0;
		div_in.den   = den_s4;
		div_in.alpha = alpha_s4;
	end

	pdb_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_word   (div_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (div_out)
	);

	assign out_red   = div_out.quo[0];
	assign out_green = div_out.quo[1];
	assign out_blue  = div_out.quo[2];
	assign out_alpha = div_out.alpha;

endmodule

`default_nettype wire

// ----- sv/pdb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] out_alpha
);

	localparam int unsigned CNT_W = $clog2(pdb_pkg::PIPE_DEPTH + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`PDB_ASSERT(a_out_hold, clk, arst_n,
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
		&& $stable(out_blue) && $stable(out_alpha), "stalled output word changed")

	`PDB_ASSERT(a_backpressure, clk, arst_n,
		!in_ready |-> out_valid && !out_ready && cnt_q == CNT_W'(pdb_pkg::PIPE_DEPTH),
		"input stalled without a full, stalled pipe")

	`PDB_ASSERT(a_no_invented, clk, arst_n,
		out_valid |-> cnt_q != '0, "output word with none in flight")

	// count is meaningless until reset has been seen
	`PDB_ASSERT_ALWAYS(a_depth, clk,
		!arst_n || cnt_q <= CNT_W'(pdb_pkg::PIPE_DEPTH), "more words in flight than stages")

endmodule

bind porter_duff_pixel_blend pdb_checker u_checker (.*);

`default_nettype wire

// ----- sim/blend_checker.sv -----
`timescale 1ns / 1ps

module blend_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [3:0] blend_mode,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] src_red,
	input  wire logic [7:0] src_green,
	input  wire logic [7:0] src_blue,
	input  wire logic [7:0] src_alpha,
	input  wire logic [7:0] dst_red,
	input  wire logic [7:0] dst_green,
	input  wire logic [7:0] dst_blue,
	input  wire logic [7:0] dst_alpha,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_red,
	input  wire logic [7:0] out_green,
	input  wire logic [7:0] out_blue,
	input  wire logic [7:0] out_alpha,
	output int              errors,
	output int              outstanding
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	rgba_t      expected_px[$];
	logic [3:0] mode_reg;
	int         fail_count = 0;
	int         depth = 0;

	assign errors = fail_count;
	assign outstanding = depth;

	// premultiply both colours, then scale back by the combined weight
	function automatic logic [7:0] unpremultiply(logic [7:0] cs, logic [7:0] cd,
			logic [31:0] ws, logic [31:0] wd, logic [31:0] den);
		logic [31:0] prem;
		if (den == 0)
			return '0;
		prem = (32'(cs) * ws + 32'(cd) * wd) / 32'(pdb_pkg::FULL_SQUARE);
		return 8'((prem * 32'(pdb_pkg::FULL_SQUARE)) / den);
	endfunction

	// expected blended pixel for one source / destination pair
	function automatic rgba_t blend_pixel(logic [3:0] mode, rgba_t s, rgba_t d);
		logic [7:0]  fs;
		logic [7:0]  fd;
		logic [7:0]  inv_s;
		logic [7:0]  inv_d;
		logic [31:0] ws;
		logic [31:0] wd;
		logic [31:0] den;
		rgba_t       r;
		inv_s = pdb_pkg::FULL_SCALE - s.alpha;
		inv_d = pdb_pkg::FULL_SCALE - d.alpha;
		case (mode)
			pdb_pkg::MODE_SRC:      begin fs = pdb_pkg::FULL_SCALE; fd = '0;    end
			pdb_pkg::MODE_DST:      begin fs = '0; fd = pdb_pkg::FULL_SCALE;    end
			pdb_pkg::MODE_OVER:     begin fs = pdb_pkg::FULL_SCALE; fd = inv_s; end
			pdb_pkg::MODE_DST_OVER: begin fs = inv_d; fd = pdb_pkg::FULL_SCALE; end
			pdb_pkg::MODE_SRC_IN:   begin fs = d.alpha;    fd = '0;         end
			pdb_pkg::MODE_DST_IN:   begin fs = '0;         fd = s.alpha;    end
			pdb_pkg::MODE_SRC_OUT:  begin fs = inv_d;      fd = '0;         end
			pdb_pkg::MODE_DST_OUT:  begin fs = '0;         fd = inv_s;      end
			pdb_pkg::MODE_SRC_ATOP: begin fs = d.alpha;    fd = inv_s;      end
			pdb_pkg::MODE_DST_ATOP: begin fs = inv_d;      fd = s.alpha;    end
			pdb_pkg::MODE_XOR:      begin fs = inv_d;      fd = inv_s;      end
			// clear and the unused codes weigh nothing
			default:                begin fs = '0;         fd = '0;         end
		endcase
		ws = 32'(s.alpha) * 32'(fs);
		wd = 32'(d.alpha) * 32'(fd);
		den = ws + wd;
		r.red   = unpremultiply(s.red,   d.red,   ws, wd, den);
		r.green = unpremultiply(s.green, d.green, ws, wd, den);
		r.blue  = unpremultiply(s.blue,  d.blue,  ws, wd, den);
		r.alpha = 8'(den / 32'(pdb_pkg::FULL_SCALE));
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// watch both channels and the mode register
	always @(posedge clk or negedge arst_n) begin : watch
		rgba_t want;
		rgba_t got;
		if (!arst_n) begin
			mode_reg <= pdb_pkg::MODE_RESET;
			expected_px.delete();
			depth = 0;
		end else begin
			// compare a word leaving the block with the oldest prediction
			if (out_valid && out_ready) begin
				got = {out_red, out_green, out_blue, out_alpha};
				if (expected_px.size() == 0) begin
					$error("unexpected pixel: red %0d green %0d blue %0d alpha %0d",
						got.red, got.green, got.blue, got.alpha);
					fail_count++;
				end else begin
					want = expected_px.pop_front();
					check_field("out_red",   want.red,   got.red);
					check_field("out_green", want.green, got.green);
					check_field("out_blue",  want.blue,  got.blue);
					check_field("out_alpha", want.alpha, got.alpha);
				end
			end
			// predict each word taken in, under the mode in force
			if (in_valid && in_ready)
				expected_px = {expected_px, blend_pixel(mode_reg,
					{src_red, src_green, src_blue, src_alpha},
					{dst_red, dst_green, dst_blue, dst_alpha})};
			if (cfg_write)
				mode_reg <= blend_mode;
			depth = expected_px.size();
		end
	end

endmodule

// ----- sim/porter_duff_pixel_blend_tb.sv -----
`timescale 1ns / 1ps

module porter_duff_pixel_blend_tb;
	import pdb_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		rgba_t src;
		rgba_t dst;
	} pixel_pair_t;

	localparam logic [3:0] MODE_TOP_CODE = 4'hF;
	localparam int PHASES         = 20;
	localparam int PIXELS_A_PHASE = 80;
	localparam int HOLD_CYCLES    = 5 * PIPE_DEPTH;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [3:0]  blend_mode = MODE_RESET;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pixel_pair_t pix = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;
	int          errors;
	int          outstanding;

	// idling controls for sender and receiver
	bit feed_steady = 1'b0;
	bit sink_steady = 1'b0;
	bit sink_hold = 1'b0;

	porter_duff_pixel_blend uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.blend_mode (blend_mode),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.src_red    (pix.src.red),
		.src_green  (pix.src.green),
		.src_blue   (pix.src.blue),
		.src_alpha  (pix.src.alpha),
		.dst_red    (pix.dst.red),
		.dst_green  (pix.dst.green),
		.dst_blue   (pix.dst.blue),
		.dst_alpha  (pix.dst.alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha)
	);

	blend_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.blend_mode  (blend_mode),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.src_red     (pix.src.red),
		.src_green   (pix.src.green),
		.src_blue    (pix.src.blue),
		.src_alpha   (pix.src.alpha),
		.dst_red     (pix.dst.red),
		.dst_green   (pix.dst.green),
		.dst_blue    (pix.dst.blue),
		.dst_alpha   (pix.dst.alpha),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_alpha   (out_alpha),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the pipe locks up
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic pixel_pair_t pair_of(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
			logic [7:0] sa, logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da);
		pixel_pair_t p;
		p.src = {sr, sg, sb, sa};
		p.dst = {dr, dg, db, da};
		return p;
	endfunction

	// channel level weighted towards the end points
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_pair_t random_pair();
		return pair_of(pick_level(), pick_level(), pick_level(), pick_level(),
			pick_level(), pick_level(), pick_level(), pick_level());
	endfunction

	// offer one word, called and returning at a falling edge
	task automatic offer_pixel(input pixel_pair_t p);
		int gap;
		gap = feed_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering and wait until every pixel has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	task automatic load_mode(input logic [3:0] m);
		cfg_write <= 1'b1;
		blend_mode <= m;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold when asked
	initial begin : sink
		int pause;
		@(posedge arst_n);
		forever begin
			pause = sink_steady ? 0 : $urandom_range(0, 10);
			if (sink_hold) begin
				pause = pause + HOLD_CYCLES;
				sink_hold = 1'b0;
			end
			if (pause > 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin : stim
		logic [3:0] mode;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset mode (src over): end points and zero combined alpha
		offer_pixel(pair_of(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		offer_pixel(pair_of(8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd255, 8'd255));
		offer_pixel(pair_of(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
		offer_pixel(pair_of(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
		offer_pixel(pair_of(8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd127, 8'd0));
		offer_pixel(pair_of(8'd17, 8'd200, 8'd99, 8'd1, 8'd240, 8'd3, 8'd64, 8'd254));

		// one pixel under every code, unused ones included
		for (int m = MODE_CLEAR; m <= MODE_TOP_CODE; m++) begin
			settle();
			load_mode(4'(m));
			offer_pixel(pair_of(8'd255, 8'd0, 8'd128, 8'd160, 8'd10, 8'd250, 8'd77, 8'd200));
		end

		// random phases, each under one mode and one idling style
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			mode = (ph <= MODE_TOP_CODE) ? 4'(ph) : 4'($urandom_range(0, 15));
			load_mode(mode);
			feed_steady = (ph % 4 == 1) || (ph % 4 == 2);
			sink_steady = (ph % 4 == 1) || (ph % 4 == 3);
			// long receiver hold with the sender pushing flat out
			if (ph == 6 || ph == 13) begin
				feed_steady = 1'b1;
				sink_hold = 1'b1;
			end
			for (int i = 0; i < PIXELS_A_PHASE; i++)
				offer_pixel(random_pair());
		end

		settle();
		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
